@@ sv/droplet_hydraulic_erosion_unit_macros.svh @@
// Assertion macros for the droplet hydraulic erosion unit checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef DROPLET_HYDRAULIC_EROSION_UNIT_MACROS_SVH
`define DROPLET_HYDRAULIC_EROSION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DHE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/dhe_pkg.sv @@
// Shared constants, codes and types for the droplet hydraulic erosion unit.
// No dependencies.
package dhe_pkg;

  localparam int GRID_RES   = 127;
  localparam int GRID_W     = GRID_RES + 1;
  localparam int GRID_CELLS = GRID_W * GRID_W;
  localparam int COORD_W    = $clog2(GRID_W);
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int H_W        = 32;
  localparam int DROP_W     = H_W + 1;
  localparam int CAP_W      = DROP_W + 16 - 8;
  localparam int SED_W      = 40;

  localparam logic [7:0] WATER_STEP_LIMIT = 8'd44;
  localparam logic [CAP_W-1:0] MIN_CAPACITY = CAP_W'(655);
  localparam logic [H_W-1:0] HEIGHT_MAX = 32'h7FFF_FFFF;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DROP  = 2'd2;

  localparam logic [2:0] CFG_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_MAX_STEPS = 3'd1;
  localparam logic [2:0] CFG_SED_CAP   = 3'd2;
  localparam logic [2:0] CFG_DEP_RATE  = 3'd3;
  localparam logic [2:0] CFG_ERO_RATE  = 3'd4;

  typedef struct packed {
    logic ld_drop;
    logic ld_cap;
    logic ld_amt;
  } sed_ctl_t;

  // Neighbor offsets in scan order, row by row from the upper left, center left out.
  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
      3'd1, 3'd6:       nb_dx = 2'sd0;
      default:          nb_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
      3'd3, 3'd4:       nb_dy = 2'sd0;
      default:          nb_dy = 2'sd1;
    endcase
  endfunction

endpackage

@@ sv/droplet_hydraulic_erosion_unit.sv @@
// Top level of the droplet hydraulic erosion unit: command sequencer around the height RAM.
// Depends on dhe_pkg, dhe_ram and dhe_sed_unit.
//
// A request is taken when start is high and busy is low; its result appears on height_out
// and steps_taken for one cycle with done high, and must be captured then, since the
// receiver cannot stall it. Writes, unused codes and droplets while disabled answer in the
// cycle after the request, reads from the S_RD state after it. A droplet passes through
// S_CHK, S_CTR, S_SCAN, S_UPD, S_CAP, S_AMT and S_WR for each move, and stops at the move
// limit or when a final scan finds a pit. Each move reads the center cell and its eight
// neighbors one at a time through the single read port of the grid RAM, then runs three
// registered arithmetic stages and writes the cell back. Heights start undefined and must
// be written before they are read.
module droplet_hydraulic_erosion_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [13:0] cell_address,
  input  logic [31:0] height_in,
  input  logic [6:0]  start_x,
  input  logic [6:0]  start_y,
  output logic        done,
  output logic [31:0] height_out,
  output logic [7:0]  steps_taken,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CWD = dhe_pkg::COORD_W;
  localparam int AW  = dhe_pkg::ADDR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_CTR  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_CAP  = 4'd6;
  localparam logic [3:0] S_AMT  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;

  logic [3:0] state;

  logic        enable;
  logic [7:0]  max_steps;
  logic [15:0] sed_capacity;
  logic [15:0] deposit_rate;
  logic [15:0] erode_rate;

  logic [CWD-1:0] x, y, nx, ny, pend_x, pend_y;
  logic [3:0]     k;
  logic           got_ctr, pend_valid;
  logic [31:0]    cur, lo;
  logic [dhe_pkg::SED_W-1:0] sed, sed_next;
  logic [7:0]     steps, limit;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata, new_height;
  dhe_pkg::sed_ctl_t sctl;

  logic signed [CWD+1:0] cx, cy;
  logic           nb_in;
  logic           accept;
  logic [CWD-1:0] sx, sy;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Clamp the start to the interior so every first scan has full neighbors.
  always_comb begin
    sx = start_x;
    sy = start_y;
    if (sx < CWD'(1)) sx = CWD'(1);
    if (sx > CWD'(dhe_pkg::GRID_W - 2)) sx = CWD'(dhe_pkg::GRID_W - 2);
    if (sy < CWD'(1)) sy = CWD'(1);
    if (sy > CWD'(dhe_pkg::GRID_W - 2)) sy = CWD'(dhe_pkg::GRID_W - 2);
  end

  assign cx = $signed({2'b00, x}) + (CWD+2)'(dhe_pkg::nb_dx(k[2:0]));
  assign cy = $signed({2'b00, y}) + (CWD+2)'(dhe_pkg::nb_dy(k[2:0]));
  assign nb_in = (cx >= 0) && (cy >= 0) && (cx < (CWD+2)'(dhe_pkg::GRID_W))
              && (cy < (CWD+2)'(dhe_pkg::GRID_W));

  always_comb begin
    ram_raddr = cell_address[AW-1:0];
    case (state)
      S_CTR:  ram_raddr = AW'(y * dhe_pkg::GRID_W + x);
      S_SCAN: ram_raddr = AW'(cy[CWD-1:0] * dhe_pkg::GRID_W + cx[CWD-1:0]);
      default: ram_raddr = cell_address[AW-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_address[AW-1:0];
    ram_wdata = height_in;
    if (accept && op == dhe_pkg::OP_WRITE
        && 32'(cell_address) < 32'(dhe_pkg::GRID_CELLS)) begin
      ram_we = 1'b1;
    end else if (state == S_WR) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(y * dhe_pkg::GRID_W + x);
      ram_wdata = new_height;
    end
  end

  always_comb begin
    sctl = '0;
    sctl.ld_drop = (state == S_UPD);
    sctl.ld_cap  = (state == S_CAP);
    sctl.ld_amt  = (state == S_AMT);
  end

  dhe_ram #(.WIDTH(32), .DEPTH(dhe_pkg::GRID_CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dhe_sed_unit u_sed (
    .clk          (clk),
    .ctl          (sctl),
    .cur          (cur),
    .lo           (lo),
    .sed          (sed),
    .sed_capacity (sed_capacity),
    .deposit_rate (deposit_rate),
    .erode_rate   (erode_rate),
    .new_height   (new_height),
    .sed_next     (sed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      max_steps    <= dhe_pkg::WATER_STEP_LIMIT;
      sed_capacity <= 16'd256;
      deposit_rate <= 16'd19661;
      erode_rate   <= 16'd19661;
    end else if (cfg_we) begin
      case (cfg_index)
        dhe_pkg::CFG_ENABLE:    enable       <= cfg_data[0];
        dhe_pkg::CFG_MAX_STEPS: max_steps    <= cfg_data[7:0];
        dhe_pkg::CFG_SED_CAP:   sed_capacity <= cfg_data;
        dhe_pkg::CFG_DEP_RATE:  deposit_rate <= cfg_data;
        dhe_pkg::CFG_ERO_RATE:  erode_rate   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            height_out  <= '0;
            steps_taken <= '0;
            if (op == dhe_pkg::OP_READ) begin
              state <= S_RD;
            end else if (op == dhe_pkg::OP_DROP && enable) begin
              x     <= sx;
              y     <= sy;
              sed   <= '0;
              steps <= '0;
              limit <= (max_steps > dhe_pkg::WATER_STEP_LIMIT) ?
                       dhe_pkg::WATER_STEP_LIMIT : max_steps;
              state <= S_CHK;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_RD: begin
          if (32'(cell_address) < 32'(dhe_pkg::GRID_CELLS)) begin
            height_out <= ram_rdata;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CHK: begin
          if (steps < limit) begin
            state <= S_CTR;
          end else begin
            steps_taken <= steps;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_CTR: begin
          k       <= '0;
          got_ctr <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          // Read data arrives in the cycle after its address is issued: compare the previous neighbor.
          if (!got_ctr) begin
            cur     <= ram_rdata;
            lo      <= ram_rdata;
            nx      <= x;
            ny      <= y;
            got_ctr <= 1'b1;
          end else if (pend_valid && $signed(ram_rdata) < $signed(lo)) begin
            lo <= ram_rdata;
            nx <= pend_x;
            ny <= pend_y;
          end
          pend_valid <= nb_in;
          pend_x     <= cx[CWD-1:0];
          pend_y     <= cy[CWD-1:0];
          k          <= k + 4'd1;
          if (k == 4'd8) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (nx == x && ny == y) begin
            steps_taken <= steps;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_CAP;
          end
        end
        S_CAP: state <= S_AMT;
        S_AMT: state <= S_WR;
        S_WR: begin
          sed   <= sed_next;
          x     <= nx;
          y     <= ny;
          steps <= steps + 8'd1;
          state <= S_CHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/dhe_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dhe_sed_unit.sv @@
// Sediment arithmetic for one droplet move: drop, capacity, deposit or erosion amount.
// Depends on dhe_pkg.
module dhe_sed_unit (
  input  logic                          clk,
  input  dhe_pkg::sed_ctl_t             ctl,
  input  logic [dhe_pkg::H_W-1:0]       cur,
  input  logic [dhe_pkg::H_W-1:0]       lo,
  input  logic [dhe_pkg::SED_W-1:0]     sed,
  input  logic [15:0]                   sed_capacity,
  input  logic [15:0]                   deposit_rate,
  input  logic [15:0]                   erode_rate,
  output logic [dhe_pkg::H_W-1:0]       new_height,
  output logic [dhe_pkg::SED_W-1:0]     sed_next
);

  localparam int CW = dhe_pkg::CAP_W;
  localparam int DW = dhe_pkg::DROP_W;

  logic [DW-1:0]      drop;
  logic [CW-1:0]      cap;
  logic [CW-1:0]      amt;
  logic               deposit;
  logic [DW+15:0]     cap_prod;
  logic [CW-1:0]      cap_raw;
  logic               dep_now;
  logic [CW-1:0]      diff;
  logic [CW+15:0]     amt_prod;
  logic [CW-1:0]      er;
  logic signed [CW+1:0] dep_sum;
  logic signed [DW:0] ero_h;

  assign cap_prod = drop * sed_capacity;
  assign cap_raw  = cap_prod[DW+15:8];
  assign dep_now  = {{(CW-dhe_pkg::SED_W){1'b0}}, sed} > cap;
  assign diff     = dep_now ? {{(CW-dhe_pkg::SED_W){1'b0}}, sed} - cap
                            : cap - {{(CW-dhe_pkg::SED_W){1'b0}}, sed};
  assign amt_prod = diff * (dep_now ? deposit_rate : erode_rate);

  always_ff @(posedge clk) begin
    if (ctl.ld_drop) begin
      drop <= {cur[dhe_pkg::H_W-1], cur} - {lo[dhe_pkg::H_W-1], lo};
    end
    if (ctl.ld_cap) begin
      cap <= (cap_raw < dhe_pkg::MIN_CAPACITY) ? dhe_pkg::MIN_CAPACITY : cap_raw;
    end
    if (ctl.ld_amt) begin
      deposit <= dep_now;
      amt     <= amt_prod[CW+15:16];
    end
  end

  // Erosion never takes more than the drop, so the cell stays at or above its neighbor.
  assign er      = (amt > {{(CW-DW){1'b0}}, drop}) ? {{(CW-DW){1'b0}}, drop} : amt;
  assign dep_sum = {{(CW+2-dhe_pkg::H_W){cur[dhe_pkg::H_W-1]}}, cur} + {2'b00, amt};
  assign ero_h   = {{2{cur[dhe_pkg::H_W-1]}}, cur} - {1'b0, er[DW-1:0]};

  always_comb begin
    if (deposit) begin
      sed_next = dhe_pkg::SED_W'(sed - amt[dhe_pkg::SED_W-1:0]);
      if (dep_sum > $signed({{(CW+2-dhe_pkg::H_W){1'b0}}, dhe_pkg::HEIGHT_MAX})) begin
        new_height = dhe_pkg::HEIGHT_MAX;
      end else begin
        new_height = dep_sum[dhe_pkg::H_W-1:0];
      end
    end else begin
      sed_next   = dhe_pkg::SED_W'(sed + er[dhe_pkg::SED_W-1:0]);
      new_height = ero_h[dhe_pkg::H_W-1:0];
    end
  end

endmodule

@@ sv/dhe_checker.sv @@
// Port-level checker for the droplet hydraulic erosion unit, bound to the top level.
// Depends on droplet_hydraulic_erosion_unit_macros.svh.
`include "droplet_hydraulic_erosion_unit_macros.svh"

module dhe_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] height_out,
  input logic [7:0]  steps_taken
);

  // An accepted request either answers at once or keeps the block busy.
  `DHE_ASSERT_NEXT(a_req_progress, start && !busy, done || busy)
  // No result without a request in flight.
  `DHE_ASSERT_NEXT(a_no_spurious, !busy && !start, !done)
  // A droplet never reports more moves than the water lasts.
  `DHE_ASSERT_NOW(a_step_bound, done, steps_taken <= 8'd44)
  // A result carries either a height or a step count, never both.
  `DHE_ASSERT_NOW(a_one_kind, done, height_out == 32'd0 || steps_taken == 8'd0)

endmodule

bind droplet_hydraulic_erosion_unit dhe_checker u_dhe_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .height_out  (height_out),
  .steps_taken (steps_taken)
);

@@ sim/tb.sv @@
// Testbench for the droplet hydraulic erosion unit: directed and random cell writes, reads
// and droplet runs, checked against a predictor of the height grid. Depends on dhe_pkg.
`timescale 1ns / 100ps

class erosion_scoreboard;
  logic [31:0] grid[int];
  logic en;
  logic [7:0] steps_max;
  logic [15:0] cap_gain, dep_rate, ero_rate;
  logic [31:0] want_height[$];
  logic [7:0] want_steps[$];
  int errors;
  int droplet_moves;

  function void reset_state();
    grid.delete();
    en = 1'b1;
    steps_max = 8'd44;
    cap_gain = 16'd256;
    dep_rate = 16'd19661;
    ero_rate = 16'd19661;
    errors = 0;
    droplet_moves = 0;
  endfunction

  function void note_config(logic [2:0] idx, logic [15:0] data);
    case (idx)
      dhe_pkg::CFG_ENABLE:    en = data[0];
      dhe_pkg::CFG_MAX_STEPS: steps_max = data[7:0];
      dhe_pkg::CFG_SED_CAP:   cap_gain = data;
      dhe_pkg::CFG_DEP_RATE:  dep_rate = data;
      dhe_pkg::CFG_ERO_RATE:  ero_rate = data;
      default: ;
    endcase
  endfunction

  function longint height_at(int a);
    logic [31:0] v;
    v = grid.exists(a) ? grid[a] : 32'd0;
    return longint'($signed(v));
  endfunction

  function int flow(int x, int y);
    int lim, n, here, nx, ny, cx, cy;
    longint cur, lo, nh;
    longint unsigned sed, drop, cap, amt;
    sed = 0;
    n = 0;
    lim = (steps_max > 44) ? 44 : steps_max;
    while (n < lim) begin
      here = y * dhe_pkg::GRID_W + x;
      cur = height_at(here);
      lo = cur;
      nx = x;
      ny = y;
      for (int oy = -1; oy <= 1; oy++)
        for (int ox = -1; ox <= 1; ox++) begin
          cx = x + ox;
          cy = y + oy;
          if (cx >= 0 && cy >= 0 && cx < dhe_pkg::GRID_W && cy < dhe_pkg::GRID_W)
            if (height_at(cy * dhe_pkg::GRID_W + cx) < lo) begin
              lo = height_at(cy * dhe_pkg::GRID_W + cx);
              nx = cx;
              ny = cy;
            end
        end
      if (nx == x && ny == y) break;
      drop = cur - lo;
      cap = (drop * cap_gain) >> 8;
      if (cap < 655) cap = 655;
      if (sed > cap) begin
        amt = ((sed - cap) * dep_rate) >> 16;
        nh = cur + longint'(amt);
        sed -= amt;
        if (nh > 64'sh7FFFFFFF) nh = 64'sh7FFFFFFF;
        grid[here] = nh[31:0];
      end else begin
        amt = ((cap - sed) * ero_rate) >> 16;
        if (amt > drop) amt = drop;
        sed += amt;
        nh = cur - longint'(amt);
        grid[here] = nh[31:0];
      end
      x = nx;
      y = ny;
      n++;
    end
    return n;
  endfunction

  function void note_request(logic [1:0] op, logic [13:0] addr, logic [31:0] h,
                             logic [6:0] sx, logic [6:0] sy);
    logic [31:0] ho;
    int st, x, y;
    ho = '0;
    st = 0;
    if (op == dhe_pkg::OP_WRITE) begin
      if (addr < dhe_pkg::GRID_CELLS) grid[addr] = h;
    end else if (op == dhe_pkg::OP_READ) begin
      if (addr < dhe_pkg::GRID_CELLS) ho = 32'(height_at(addr));
    end else if (op == dhe_pkg::OP_DROP && en) begin
      x = (sx < 1) ? 1 : (sx > dhe_pkg::GRID_W - 2) ? dhe_pkg::GRID_W - 2 : sx;
      y = (sy < 1) ? 1 : (sy > dhe_pkg::GRID_W - 2) ? dhe_pkg::GRID_W - 2 : sy;
      st = flow(x, y);
      droplet_moves += st;
    end
    want_height.push_back(ho);
    want_steps.push_back(st[7:0]);
  endfunction

  function void check_result(logic [31:0] h, logic [7:0] s);
    if (want_height.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    if (h !== want_height[0]) begin
      $error("height_out expected %h actual %h", want_height[0], h);
      errors++;
    end
    if (s !== want_steps[0]) begin
      $error("steps_taken expected %0d actual %0d", want_steps[0], s);
      errors++;
    end
    void'(want_height.pop_front());
    void'(want_steps.pop_front());
  endfunction
endclass

module tb;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, cfg_we = 1'b0;
  logic busy, done;
  logic [1:0] op = '0;
  logic [13:0] cell_address = '0;
  logic [31:0] height_in = '0, height_out;
  logic [6:0] start_x = '0, start_y = '0;
  logic [7:0] steps_taken;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  erosion_scoreboard sb;
  int idle_cycles = 0;
  int requests = 0;

  droplet_hydraulic_erosion_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(height_out, steps_taken);
      idle_cycles = (done || (start && !busy)) ? 0 : idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic issue(logic [1:0] o, logic [13:0] a, logic [31:0] h,
                       logic [6:0] sx, logic [6:0] sy);
    repeat ($urandom_range(0, 10)) @(negedge clk);
    op = o;
    cell_address = a;
    height_in = h;
    start_x = sx;
    start_y = sy;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(o, a, h, sx, sy);
    requests++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (sb.want_height.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] data);
    drain();
    cfg_index = idx;
    cfg_data = data;
    cfg_we = 1'b1;
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Terrain of a small window: a bowl with random ripples inside a ring at the largest
  // height, which no droplet can enter, so every droplet stays on written cells.
  task automatic paint(int x0, int y0, int sz, bit wild);
    logic [31:0] h;
    for (int y = y0; y < y0 + sz; y++)
      for (int x = x0; x < x0 + sz; x++) begin
        if (x == x0 || y == y0 || x == x0 + sz - 1 || y == y0 + sz - 1) begin
          h = dhe_pkg::HEIGHT_MAX;
        end else begin
          h = ((x - x0 - sz / 2) ** 2 + (y - y0 - sz / 2) ** 2) * 32'h8000
              + $urandom_range(0, 32'h40000);
          if (wild && $urandom_range(0, 7) == 0) h = $urandom;
        end
        issue(dhe_pkg::OP_WRITE, 14'(y * dhe_pkg::GRID_W + x), h, 7'd0, 7'd0);
      end
  endtask

  task automatic droplets_in(int x0, int y0, int sz, int n);
    int a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: issue(dhe_pkg::OP_DROP, 14'($urandom), $urandom,
                 7'(x0 + $urandom_range(1, sz - 2)), 7'(y0 + $urandom_range(1, sz - 2)));
        1: begin
          a = (y0 + $urandom_range(0, sz - 1)) * dhe_pkg::GRID_W + x0
              + $urandom_range(0, sz - 1);
          issue(dhe_pkg::OP_READ, 14'(a), $urandom, 7'($urandom), 7'($urandom));
        end
        2: issue(OP_UNUSED, 14'($urandom), $urandom, 7'($urandom), 7'($urandom));
        default: issue(dhe_pkg::OP_READ, 14'(dhe_pkg::GRID_CELLS - 1), $urandom, 7'd0, 7'd0);
      endcase
    end
  endtask

  initial begin
    logic [15:0] rates[4];
    sb = new();
    sb.reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: whole grid corners, extremes of height, clamps, border, ties.
    issue(dhe_pkg::OP_WRITE, 14'd0, 32'h8000_0000, 7'd0, 7'd0);
    issue(dhe_pkg::OP_WRITE, 14'(dhe_pkg::GRID_CELLS - 1), 32'h7FFF_FFFF, 7'd0, 7'd0);
    issue(dhe_pkg::OP_READ, 14'd0, 32'd0, 7'd0, 7'd0);
    issue(dhe_pkg::OP_READ, 14'(dhe_pkg::GRID_CELLS - 1), 32'd0, 7'd0, 7'd0);
    issue(dhe_pkg::OP_WRITE, 14'h3FFF, 32'h1234_5678, 7'd0, 7'd0);
    issue(dhe_pkg::OP_READ, 14'h3FFF, 32'hFFFF_FFFF, 7'h7F, 7'h7F);
    issue(OP_UNUSED, 14'h3FFF, 32'hFFFF_FFFF, 7'h7F, 7'h7F);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) begin
        issue(dhe_pkg::OP_WRITE, 14'(y * dhe_pkg::GRID_W + x), 32'h0001_0000, 7'd0, 7'd0);
        issue(dhe_pkg::OP_WRITE,
              14'((dhe_pkg::GRID_W - 3 + y) * dhe_pkg::GRID_W + dhe_pkg::GRID_W - 3 + x),
              32'h7FFF_0000, 7'd0, 7'd0);
      end
    // Tie: two equal lowest neighbors; the first in scan order must win.
    issue(dhe_pkg::OP_WRITE, 14'd1, 32'h0000_8000, 7'd0, 7'd0);
    issue(dhe_pkg::OP_WRITE, 14'(dhe_pkg::GRID_W), 32'h0000_8000, 7'd0, 7'd0);
    issue(dhe_pkg::OP_DROP, 14'd0, 32'd0, 7'd0, 7'd0);
    issue(dhe_pkg::OP_DROP, 14'd0, 32'd0, 7'h7F, 7'h7F);
    issue(dhe_pkg::OP_READ, 14'd0, 32'd0, 7'd0, 7'd0);
    set_reg(dhe_pkg::CFG_ENABLE, 16'hFFFE);
    issue(dhe_pkg::OP_DROP, 14'd0, 32'd0, 7'h7F, 7'h7F);
    set_reg(dhe_pkg::CFG_ENABLE, 16'd1);
    set_reg(CFG_UNUSED, 16'hFFFF);

    // Sender holds off until the block has answered everything.
    drain();

    rates = '{16'd0, 16'hFFFF, 16'd19661, 16'd300};
    for (int ph = 0; ph < 16; ph++) begin
      int x0, y0, sz;
      sz = $urandom_range(4, 8);
      x0 = (ph % 2) ? dhe_pkg::GRID_W - sz : $urandom_range(0, dhe_pkg::GRID_W - sz);
      y0 = (ph % 4 < 2) ? $urandom_range(0, dhe_pkg::GRID_W - sz) : 0;
      set_reg(dhe_pkg::CFG_MAX_STEPS,
              (ph == 3) ? 16'd0 : (ph == 5) ? 16'hFFFF : 16'($urandom_range(2, 60)));
      set_reg(dhe_pkg::CFG_SED_CAP,
              (ph % 3 == 0) ? 16'hFFFF : (ph % 3 == 1) ? 16'd0 : 16'($urandom));
      set_reg(dhe_pkg::CFG_DEP_RATE, rates[ph % 4]);
      set_reg(dhe_pkg::CFG_ERO_RATE, rates[(ph / 4) % 4]);
      set_reg(dhe_pkg::CFG_ENABLE, (ph == 7) ? 16'd0 : 16'd1);
      paint(x0, y0, sz, bit'(ph % 2));
      droplets_in(x0, y0, sz, 30);
    end
    drain();
    repeat (700) @(negedge clk);
    $display("Covered %0d requests over 16 terrain windows, %0d droplet moves in total.",
             requests, sb.droplet_moves);
    if (sb.errors == 0 && sb.want_height.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
